FILE: rtl/hidrd_pkg.sv
// Shared types and constants of the HID report descriptor parser.
`default_nettype none
package hidrd_pkg;

  localparam logic [1:0] CMD_BYTE    = 2'd0;
  localparam logic [1:0] CMD_ID      = 2'd1;
  localparam logic [1:0] CMD_FIT     = 2'd2;
  localparam logic [1:0] CMD_LARGEST = 2'd3;

  localparam logic [1:0] ST_BYTE  = 2'd0;
  localparam logic [1:0] ST_OK    = 2'd1;
  localparam logic [1:0] ST_DFLT  = 2'd2;
  localparam logic [1:0] ST_QUERY = 2'd3;

  localparam logic [7:0] TAG_USAGE  = 8'h08;
  localparam logic [7:0] TAG_REPID  = 8'h84;
  localparam logic [7:0] TAG_RCOUNT = 8'h94;
  localparam logic [7:0] TAG_INPUT  = 8'h80;
  localparam logic [7:0] TAG_OUTPUT = 8'h90;

  localparam logic [15:0] DFLT_MAX      = 16'd63;
  localparam logic [15:0] DFLT_MISS_ID  = 16'd9;
  localparam logic [15:0] DFLT_MISS_SZ  = 16'd64;
  localparam int          DFLT_IN_CNT   = 4;
  localparam int          DFLT_OUT_CNT  = 5;

  function automatic logic [15:0] dflt_in_size(input logic [2:0] i);
    case (i)
      3'd0:    dflt_in_size = 16'd13;
      3'd1:    dflt_in_size = 16'd15;
      3'd2:    dflt_in_size = 16'd21;
      3'd3:    dflt_in_size = 16'd64;
      default: dflt_in_size = 16'd0;
    endcase
  endfunction

  function automatic logic [15:0] dflt_out_size(input logic [2:0] i);
    case (i)
      3'd0:    dflt_out_size = 16'd9;
      3'd1:    dflt_out_size = 16'd11;
      3'd2:    dflt_out_size = 16'd15;
      3'd3:    dflt_out_size = 16'd21;
      3'd4:    dflt_out_size = 16'd64;
      default: dflt_out_size = 16'd0;
    endcase
  endfunction

  // classified job passed from front to back
  typedef struct packed {
    logic [1:0]  cmd;
    logic        run;      // a complete item is ready
    logic [7:0]  tag;
    logic [31:0] value;
    logic        start;    // first byte of a parse
    logic        last;
    logic [15:0] qsize;
  } job_t;

  typedef struct packed {
    logic [15:0] reply_value;
    logic [1:0]  status;
    logic [4:0]  input_reports;
    logic [4:0]  output_reports;
    logic [15:0] largest_input;
    logic [15:0] largest_output;
  } res_t;

endpackage
`default_nettype wire

FILE: rtl/hidrd_if.sv
// Valid/ready channel interfaces of the parser.
`default_nettype none
interface hidrd_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [7:0]  data_byte;
  logic        last_byte;
  logic [15:0] query_size;
  modport source (output valid, command, data_byte, last_byte, query_size, input ready);
  modport sink   (input valid, command, data_byte, last_byte, query_size, output ready);
endinterface

interface hidrd_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] reply_value;
  logic [1:0]  status;
  logic [4:0]  input_reports;
  logic [4:0]  output_reports;
  logic [15:0] largest_input;
  logic [15:0] largest_output;
  modport source (output valid, reply_value, status, input_reports, output_reports,
                  largest_input, largest_output, input ready);
  modport sink   (input valid, reply_value, status, input_reports, output_reports,
                  largest_input, largest_output, output ready);
endinterface
`default_nettype wire

FILE: rtl/hidrd_front.sv
// Front end: short item byte decoder that classifies transfers into jobs.
`default_nettype none
module hidrd_front (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire logic [1:0]     in_command,
  input  wire logic [7:0]     in_data_byte,
  input  wire logic           in_last_byte,
  input  wire logic [15:0]    in_query_size,
  output logic                job_valid,
  input  wire logic           job_ready,
  output hidrd_pkg::job_t     job
);
  logic [2:0]  left_r, left_nxt;
  logic [7:0]  tag_r, tag_nxt;
  logic [1:0]  idx_r, idx_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic        started_r, started_nxt;
  logic        fire;

  assign in_ready  = job_ready;
  assign job_valid = in_valid;
  assign fire      = in_valid && job_ready;

  always_comb begin
    logic [2:0]  left0;
    logic [31:0] acc0;
    logic [1:0]  code;
    left0 = started_r ? left_r : 3'd0;
    acc0  = started_r ? acc_r : 32'd0;
    left_nxt = left0;
    tag_nxt  = started_r ? tag_r : 8'd0;
    idx_nxt  = started_r ? idx_r : 2'd0;
    acc_nxt  = acc0;
    started_nxt = 1'b1;
    job.cmd   = in_command;
    job.run   = 1'b0;
    job.tag   = 8'd0;
    job.value = 32'd0;
    job.start = !started_r;
    job.last  = in_last_byte;
    job.qsize = in_query_size;
    code = in_data_byte[1:0];
    if (left0 == 3'd0) begin
      tag_nxt  = {in_data_byte[7:2], 2'b00};
      idx_nxt  = 2'd0;
      acc_nxt  = 32'd0;
      left_nxt = (code == 2'd3) ? 3'd4 : {1'b0, code};
      job.tag  = tag_nxt;
      job.run  = (code == 2'd0);
    end else begin
      acc_nxt = acc0 | ({24'd0, in_data_byte} << {idx_nxt, 3'b000});
      acc_nxt = acc0 | ({24'd0, in_data_byte} << {(started_r ? idx_r : 2'd0), 3'b000});
      idx_nxt = (started_r ? idx_r : 2'd0) + 2'd1;
      left_nxt = left0 - 3'd1;
      job.tag   = tag_nxt;
      job.value = acc_nxt;
      job.run   = (left_nxt == 3'd0);
    end
    if (in_last_byte) begin
      left_nxt = 3'd0;
      idx_nxt  = 2'd0;
      started_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r <= 3'd0;
      tag_r <= 8'd0;
      idx_r <= 2'd0;
      acc_r <= 32'd0;
      started_r <= 1'b0;
    end else if (fire && in_command == hidrd_pkg::CMD_BYTE) begin
      left_r <= left_nxt;
      tag_r <= tag_nxt;
      idx_r <= idx_nxt;
      acc_r <= acc_nxt;
      started_r <= started_nxt;
    end
  end
endmodule
`default_nettype wire

FILE: rtl/hidrd_queue.sv
// Two-entry job queue between front and back ends.
`default_nettype none
module hidrd_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            wr_valid,
  output logic                 wr_ready,
  input  wire hidrd_pkg::job_t wr_data,
  output logic                 rd_valid,
  input  wire logic            rd_ready,
  output hidrd_pkg::job_t      rd_data
);
  hidrd_pkg::job_t mem_r [2];
  logic            wp_r, rp_r;
  logic [1:0]      cnt_r;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr_valid && wr_ready) mem_r[wp_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr_valid && wr_ready) wp_r <= !wp_r;
      if (rd_valid && rd_ready) rp_r <= !rp_r;
      cnt_r <= cnt_r + {1'b0, wr_valid && wr_ready} - {1'b0, rd_valid && rd_ready};
    end
  end
endmodule
`default_nettype wire

FILE: rtl/hidrd_back.sv
// Back end: pending item, report tables, end-of-parse and table scan for queries.
`default_nettype none
module hidrd_back #(
  parameter int MAX_REPORTS = 16
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            job_valid,
  output logic                 job_ready,
  input  wire hidrd_pkg::job_t job,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output hidrd_pkg::res_t      res
);
  localparam int IW = $clog2(MAX_REPORTS);
  localparam int CW = $clog2(MAX_REPORTS + 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_DFLT = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t       state_r;
  logic [7:0]   in_ids_r  [MAX_REPORTS];
  logic [15:0]  in_sz_r   [MAX_REPORTS];
  logic [7:0]   out_ids_r [MAX_REPORTS];
  logic [15:0]  out_sz_r  [MAX_REPORTS];
  logic [CW-1:0] in_cnt_r, out_cnt_r;
  logic [15:0]  max_in_r, max_out_r;
  logic         p_usage_r;
  logic [7:0]   p_id_r;
  logic [15:0]  p_cnt_r;
  hidrd_pkg::job_t job_r;
  logic [CW-1:0] scan_r;
  logic [IW-1:0] sidx;
  logic [15:0]  reply_r;
  logic [1:0]   status_r;

  assign job_ready = (state_r == S_IDLE) && !out_valid;
  assign sidx = scan_r[IW-1:0];

  assign res.reply_value    = reply_r;
  assign res.status         = status_r;
  assign res.input_reports  = 5'(in_cnt_r);
  assign res.output_reports = 5'(out_cnt_r);
  assign res.largest_input  = max_in_r;
  assign res.largest_output = max_out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_DFLT;
      out_valid <= 1'b0;
      p_usage_r <= 1'b0;
      p_id_r    <= 8'd0;
      p_cnt_r   <= 16'd0;
      in_cnt_r  <= CW'(hidrd_pkg::DFLT_IN_CNT);
      out_cnt_r <= CW'(hidrd_pkg::DFLT_OUT_CNT);
      max_in_r  <= hidrd_pkg::DFLT_MAX;
      max_out_r <= hidrd_pkg::DFLT_MAX;
      scan_r    <= '0;
      status_r  <= hidrd_pkg::ST_BYTE;
      reply_r   <= 16'd0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (job_valid && job_ready) begin
            job_r  <= job;
            if (job.cmd != hidrd_pkg::CMD_BYTE) begin
              status_r <= hidrd_pkg::ST_QUERY;
              if (job.cmd != hidrd_pkg::CMD_ID && job.qsize >= max_out_r) begin
                reply_r   <= max_out_r;
                out_valid <= 1'b1;
              end else begin
                scan_r  <= (job.cmd == hidrd_pkg::CMD_LARGEST) ? out_cnt_r : '0;
                state_r <= S_SCAN;
              end
            end else begin : byte_job
              logic [CW-1:0] ic, oc;
              logic          up;
              logic [7:0]    pid;
              logic [15:0]   pc, mi, mo;
              reply_r <= 16'd0;
              // entries above the counts are never read; a new parse clears counts, not entries
              ic = job.start ? '0 : in_cnt_r;
              oc = job.start ? '0 : out_cnt_r;
              mi = job.start ? 16'd0 : max_in_r;
              mo = job.start ? 16'd0 : max_out_r;
              up  = job.start ? 1'b0 : p_usage_r;
              pid = job.start ? 8'd0 : p_id_r;
              pc  = job.start ? 16'd0 : p_cnt_r;
              if (job.run) begin
                case (job.tag)
                  hidrd_pkg::TAG_USAGE: begin
                    up = 1'b1; pid = 8'd0; pc = 16'd0;
                  end
                  hidrd_pkg::TAG_REPID:  pid = job.value[7:0];
                  hidrd_pkg::TAG_RCOUNT: pc = (job.value > 32'hFFFF) ? 16'hFFFF
                                              : job.value[15:0];
                  hidrd_pkg::TAG_INPUT, hidrd_pkg::TAG_OUTPUT: begin : rec
                    logic [15:0] sz;
                    sz = (pc == 16'hFFFF) ? 16'hFFFF : pc + 16'd1;
                    if (up && pc != 16'd0) begin
                      if (job.tag == hidrd_pkg::TAG_INPUT) begin
                        if (ic < CW'(MAX_REPORTS)) begin
                          in_ids_r[ic[IW-1:0]] <= pid;
                          in_sz_r[ic[IW-1:0]]  <= sz;
                          if (mi < sz) mi = sz;
                          ic = ic + 1'b1;
                        end
                      end else if (oc < CW'(MAX_REPORTS)) begin
                        out_ids_r[oc[IW-1:0]] <= pid;
                        out_sz_r[oc[IW-1:0]]  <= sz;
                        if (mo < sz) mo = sz;
                        oc = oc + 1'b1;
                      end
                    end
                  end
                  default: ;
                endcase
              end
              in_cnt_r <= ic; out_cnt_r <= oc;
              max_in_r <= mi; max_out_r <= mo;
              p_usage_r <= up; p_id_r <= pid; p_cnt_r <= pc;
              if (job.last && (ic == '0 || oc == '0)) begin
                status_r <= hidrd_pkg::ST_DFLT;
                state_r  <= S_DFLT;
              end else begin
                status_r  <= job.last ? hidrd_pkg::ST_OK : hidrd_pkg::ST_BYTE;
                out_valid <= 1'b1;
              end
            end
          end
        end
        S_SCAN: begin
          if (job_r.cmd == hidrd_pkg::CMD_LARGEST) begin
            if (scan_r == '0) begin
              reply_r <= hidrd_pkg::DFLT_MISS_SZ;
              state_r <= S_DONE;
            end else begin
              if (job_r.qsize >= out_sz_r[IW'(scan_r - 1'b1)]) begin
                reply_r <= out_sz_r[IW'(scan_r - 1'b1)];
                state_r <= S_DONE;
              end
              scan_r <= scan_r - 1'b1;
            end
          end else if (scan_r >= out_cnt_r) begin
            reply_r <= (job_r.cmd == hidrd_pkg::CMD_ID) ? hidrd_pkg::DFLT_MISS_ID
                                                       : hidrd_pkg::DFLT_MISS_SZ;
            state_r <= S_DONE;
          end else begin
            if (job_r.cmd == hidrd_pkg::CMD_ID && job_r.qsize == out_sz_r[sidx]) begin
              reply_r <= {8'd0, out_ids_r[sidx]};
              state_r <= S_DONE;
            end else if (job_r.cmd == hidrd_pkg::CMD_FIT && job_r.qsize <= out_sz_r[sidx]) begin
              reply_r <= out_sz_r[sidx];
              state_r <= S_DONE;
            end
            scan_r <= scan_r + 1'b1;
          end
        end
        S_DFLT: begin
          for (int i = 0; i < MAX_REPORTS; i++) begin
            in_ids_r[i]  <= (i < hidrd_pkg::DFLT_IN_CNT) ? 8'(i + 1) : 8'd0;
            in_sz_r[i]   <= hidrd_pkg::dflt_in_size(3'(i < 8 ? i : 7));
            out_ids_r[i] <= (i < hidrd_pkg::DFLT_OUT_CNT) ? 8'(i + 5) : 8'd0;
            out_sz_r[i]  <= hidrd_pkg::dflt_out_size(3'(i < 8 ? i : 7));
          end
          in_cnt_r  <= CW'(hidrd_pkg::DFLT_IN_CNT);
          out_cnt_r <= CW'(hidrd_pkg::DFLT_OUT_CNT);
          max_in_r  <= hidrd_pkg::DFLT_MAX;
          max_out_r <= hidrd_pkg::DFLT_MAX;
          // after reset no result is owed
          if (status_r == hidrd_pkg::ST_DFLT) out_valid <= 1'b1;
          state_r <= S_IDLE;
        end
        S_DONE: begin
          out_valid <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: rtl/hid_report_descriptor_parser.sv
// Top level of the HID report descriptor short item parser.
// A descriptor byte passes the combinational front end, the queue and the back end,
// whose result is registered (after state S_DFLT when defaults are reloaded at the end
// of a parse); a query not answered at once from the largest output size scans the
// output table one entry per cycle. One result transfer follows every input transfer.
// After reset is released the back end loads the default tables in state S_DFLT;
// transfers taken meanwhile wait in the queue.
`default_nettype none
module hid_report_descriptor_parser #(
  parameter int MAX_REPORTS = 16
) (
  input wire logic    clk,
  input wire logic    rst_n,
  hidrd_in_if.sink    in_ch,
  hidrd_out_if.source out_ch
);
  logic            f_valid, f_ready, q_valid, q_ready;
  hidrd_pkg::job_t f_job, q_job;
  hidrd_pkg::res_t res;

  hidrd_front u_front (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_command(in_ch.command), .in_data_byte(in_ch.data_byte),
    .in_last_byte(in_ch.last_byte), .in_query_size(in_ch.query_size),
    .job_valid(f_valid), .job_ready(f_ready), .job(f_job)
  );

  hidrd_queue u_queue (
    .clk, .rst_n,
    .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_job),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_job)
  );

  hidrd_back #(.MAX_REPORTS(MAX_REPORTS)) u_back (
    .clk, .rst_n,
    .job_valid(q_valid), .job_ready(q_ready), .job(q_job),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .res(res)
  );

  assign out_ch.reply_value    = res.reply_value;
  assign out_ch.status         = res.status;
  assign out_ch.input_reports  = res.input_reports;
  assign out_ch.output_reports = res.output_reports;
  assign out_ch.largest_input  = res.largest_input;
  assign out_ch.largest_output = res.largest_output;
endmodule
`default_nettype wire

FILE: dv/hidrd_test_if.sv
// Testbench package: table depth of the parser under test.
`timescale 1ns / 100ps
package hidrd_test_pkg;
  // depth of the report tables in the parser under test
  localparam int TABLE_DEPTH = 16;
endpackage

FILE: dv/hid_report_descriptor_parser_test.sv
// Testbench of the HID report descriptor parser: directed table, random descriptors, predictor.
`timescale 1ns / 100ps
module hid_report_descriptor_parser_test;
  import hidrd_pkg::*;
  import hidrd_test_pkg::*;

  logic clk;
  logic rst_n;

  hidrd_in_if  in_ch ();
  hidrd_out_if out_ch ();

  hid_report_descriptor_parser #(.MAX_REPORTS(TABLE_DEPTH)) uut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  typedef struct packed {
    logic [1:0]  command;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic [15:0] query_size;
  } item_t;

  // parser state mirrored by the predictor
  logic [2:0]  dec_left;
  logic [7:0]  dec_tag;
  logic [1:0]  dec_idx;
  logic [31:0] dec_acc;
  logic        pnd_usage;
  logic [7:0]  pnd_id;
  logic [15:0] pnd_count;
  logic        parsing;
  logic [7:0]  tin_id [TABLE_DEPTH];
  logic [15:0] tin_sz [TABLE_DEPTH];
  logic [7:0]  tout_id [TABLE_DEPTH];
  logic [15:0] tout_sz [TABLE_DEPTH];
  logic [4:0]  n_in, n_out;
  logic [15:0] big_in, big_out;

  res_t   expected_q [$];
  item_t  stim_q [$];
  res_t   typed_q [$];
  logic   typed_has [$];
  int     fails;
  int     idle_cycles;
  bit     stim_done;
  bit     hold_off;

  task automatic clear_tables();
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      tin_id[i] = '0; tin_sz[i] = '0; tout_id[i] = '0; tout_sz[i] = '0;
    end
    n_in = '0; n_out = '0; big_in = '0; big_out = '0;
  endtask

  task automatic load_default_tables();
    clear_tables();
    for (int i = 0; i < DFLT_IN_CNT; i++) begin
      tin_id[i] = 8'(i + 1); tin_sz[i] = dflt_in_size(3'(i));
    end
    for (int i = 0; i < DFLT_OUT_CNT; i++) begin
      tout_id[i] = 8'(i + 5); tout_sz[i] = dflt_out_size(3'(i));
    end
    n_in = 5'(DFLT_IN_CNT); n_out = 5'(DFLT_OUT_CNT);
    big_in = DFLT_MAX; big_out = DFLT_MAX;
  endtask

  task automatic predictor_reset();
    dec_left = '0; dec_tag = '0; dec_idx = '0; dec_acc = '0;
    pnd_usage = 0; pnd_id = '0; pnd_count = '0; parsing = 0;
    load_default_tables();
  endtask

  task automatic finish_item(input logic [7:0] tag, input logic [31:0] value);
    logic [16:0] sz;
    sz = 17'(pnd_count) + 17'd1;
    if (sz > 17'hFFFF) sz = 17'hFFFF;
    case (tag)
      TAG_USAGE: begin
        pnd_usage = 1; pnd_id = '0; pnd_count = '0;
      end
      TAG_REPID: pnd_id = value[7:0];
      TAG_RCOUNT: pnd_count = (value > 32'hFFFF) ? 16'hFFFF : value[15:0];
      TAG_INPUT: begin
        if (pnd_usage && pnd_count != 0 && n_in < TABLE_DEPTH) begin
          tin_id[n_in] = pnd_id; tin_sz[n_in] = sz[15:0];
          if (big_in < sz[15:0]) big_in = sz[15:0];
          n_in++;
        end
      end
      TAG_OUTPUT: begin
        if (pnd_usage && pnd_count != 0 && n_out < TABLE_DEPTH) begin
          tout_id[n_out] = pnd_id; tout_sz[n_out] = sz[15:0];
          if (big_out < sz[15:0]) big_out = sz[15:0];
          n_out++;
        end
      end
      default: ;
    endcase
  endtask

  function automatic logic [15:0] answer_query(input logic [1:0] cmd, input logic [15:0] qs);
    if (cmd == CMD_ID) begin
      for (int i = 0; i < n_out; i++) if (qs == tout_sz[i]) return 16'(tout_id[i]);
      return DFLT_MISS_ID;
    end
    if (qs >= big_out) return big_out;
    if (cmd == CMD_FIT) begin
      for (int i = 0; i < n_out; i++) if (qs <= tout_sz[i]) return tout_sz[i];
      return DFLT_MISS_SZ;
    end
    for (int i = n_out; i > 0; i--) if (qs >= tout_sz[i-1]) return tout_sz[i-1];
    return DFLT_MISS_SZ;
  endfunction

  task automatic predict_result(input item_t it, output res_t r);
    r = '0;
    if (it.command == CMD_BYTE) begin
      r.status = ST_BYTE;
      if (!parsing) begin
        clear_tables();
        pnd_usage = 0; pnd_id = '0; pnd_count = '0;
        dec_left = '0; dec_tag = '0; dec_idx = '0; dec_acc = '0;
        parsing = 1;
      end
      if (dec_left == 0) begin
        dec_tag = {it.data_byte[7:2], 2'b00};
        dec_idx = '0; dec_acc = '0;
        dec_left = (it.data_byte[1:0] == 2'd3) ? 3'd4 : {1'b0, it.data_byte[1:0]};
        if (dec_left == 0) finish_item(dec_tag, '0);
      end else begin
        dec_acc |= 32'(it.data_byte) << (dec_idx * 8);
        dec_idx++;
        dec_left--;
        if (dec_left == 0) finish_item(dec_tag, dec_acc);
      end
      if (it.last_byte) begin
        dec_left = '0; dec_idx = '0; parsing = 0;
        if (n_in == 0 || n_out == 0) begin
          load_default_tables();
          r.status = ST_DFLT;
        end else r.status = ST_OK;
      end
    end else begin
      r.reply_value = answer_query(it.command, it.query_size);
      r.status = ST_QUERY;
    end
    r.input_reports = n_in; r.output_reports = n_out;
    r.largest_input = big_in; r.largest_output = big_out;
  endtask

  function automatic item_t byte_item(input logic [7:0] b, input logic last);
    item_t it;
    it = '0; it.command = CMD_BYTE; it.data_byte = b; it.last_byte = last;
    it.query_size = 16'($urandom);
    return it;
  endfunction

  function automatic item_t query_item(input logic [1:0] cmd, input logic [15:0] qs);
    item_t it;
    it = '0; it.command = cmd; it.query_size = qs;
    it.data_byte = 8'($urandom); it.last_byte = 1'($urandom);
    return it;
  endfunction

  task automatic push_stim(input item_t it);
    stim_q.push_back(it);
  endtask

  // one Usage / Report ID / Report Count / Input-or-Output group, random Report Count field width
  task automatic push_report(input logic is_out, input logic [7:0] id, input logic [31:0] cnt);
    logic [1:0] w;
    push_stim(byte_item(TAG_USAGE | 8'd1, 0));
    push_stim(byte_item(8'($urandom), 0));
    push_stim(byte_item(TAG_REPID | 8'd1, 0));
    push_stim(byte_item(id, 0));
    w = (cnt > 32'hFFFF) ? 2'd3 : (cnt > 32'hFF) ? 2'd2 : 2'($urandom_range(1, 3));
    push_stim(byte_item(TAG_RCOUNT | 8'(w), 0));
    for (int i = 0; i < ((w == 3) ? 4 : w); i++) push_stim(byte_item(cnt[i*8 +: 8], 0));
    push_stim(byte_item(is_out ? TAG_OUTPUT : TAG_INPUT, 0));
  endtask

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // input side
  initial begin
    item_t it;
    res_t  r;
    in_ch.valid = 0; in_ch.command = '0; in_ch.data_byte = '0;
    in_ch.last_byte = 0; in_ch.query_size = '0;
    rst_n = 0;
    stim_done = 0;
    predictor_reset();
    repeat (8) @(posedge clk);
    @(negedge clk) rst_n = 1;
    repeat (3) @(negedge clk);

    // directed rows: {item, typed result, typed-in result valid}
    begin
      item_t rows [$];
      res_t  rres [$];
      logic  rhas [$];
      rows.push_back(query_item(CMD_ID, 16'd9));
      rres.push_back('{16'd5, ST_QUERY, 5'd4, 5'd5, 16'd63, 16'd63}); rhas.push_back(1);
      rows.push_back(query_item(CMD_ID, 16'hFFFF));
      rres.push_back('{16'd9, ST_QUERY, 5'd4, 5'd5, 16'd63, 16'd63}); rhas.push_back(1);
      rows.push_back(query_item(CMD_FIT, 16'd0));
      rres.push_back('{16'd9, ST_QUERY, 5'd4, 5'd5, 16'd63, 16'd63}); rhas.push_back(1);
      rows.push_back(query_item(CMD_FIT, 16'hFFFF));
      rres.push_back('{16'd63, ST_QUERY, 5'd4, 5'd5, 16'd63, 16'd63}); rhas.push_back(1);
      rows.push_back(query_item(CMD_LARGEST, 16'd0));
      rres.push_back('{16'd64, ST_QUERY, 5'd4, 5'd5, 16'd63, 16'd63}); rhas.push_back(1);
      rows.push_back(query_item(CMD_LARGEST, 16'd20));
      rres.push_back('{16'd15, ST_QUERY, 5'd4, 5'd5, 16'd63, 16'd63}); rhas.push_back(1);
      // single last byte with no reports: tables empty, defaults reloaded
      rows.push_back(byte_item(8'hFF, 1));
      rres.push_back('{16'd0, ST_DFLT, 5'd4, 5'd5, 16'd63, 16'd63}); rhas.push_back(1);
      // long item prefix skipped, then parse cut short while waiting for data
      rows.push_back(byte_item(8'hFE, 0)); rres.push_back('0); rhas.push_back(0);
      rows.push_back(byte_item(8'h00, 0)); rres.push_back('0); rhas.push_back(0);
      rows.push_back(byte_item(8'hFF, 0)); rres.push_back('0); rhas.push_back(0);
      rows.push_back(byte_item(8'h00, 0)); rres.push_back('0); rhas.push_back(0);
      rows.push_back(byte_item(TAG_USAGE, 0)); rres.push_back('0); rhas.push_back(0);
      rows.push_back(byte_item(TAG_RCOUNT | 8'd3, 0)); rres.push_back('0); rhas.push_back(0);
      rows.push_back(byte_item(8'hFF, 0)); rres.push_back('0); rhas.push_back(0);
      rows.push_back(byte_item(8'hFF, 0)); rres.push_back('0); rhas.push_back(0);
      rows.push_back(byte_item(8'hFF, 0)); rres.push_back('0); rhas.push_back(0);
      rows.push_back(byte_item(8'hFF, 0)); rres.push_back('0); rhas.push_back(0);
      rows.push_back(byte_item(TAG_OUTPUT, 0)); rres.push_back('0); rhas.push_back(0);
      rows.push_back(byte_item(TAG_INPUT, 0)); rres.push_back('0); rhas.push_back(0);
      rows.push_back(byte_item(TAG_REPID | 8'd2, 1)); rres.push_back('0); rhas.push_back(0);
      rows.push_back(query_item(CMD_ID, 16'hFFFF)); rres.push_back('0); rhas.push_back(0);
      rows.push_back(query_item(CMD_FIT, 16'd1)); rres.push_back('0); rhas.push_back(0);
      rows.push_back(query_item(CMD_LARGEST, 16'hFFFE)); rres.push_back('0); rhas.push_back(0);
      foreach (rows[i]) begin
        stim_q.push_back(rows[i]);
        typed_q.push_back(rres[i]);
        typed_has.push_back(rhas[i]);
      end
    end

    // random part: mostly well-formed descriptors with random content
    while (stim_q.size() < 520) begin
      int k;
      k = $urandom_range(0, 9);
      if (k < 6) begin
        int nrep;
        nrep = ($urandom_range(0, 7) == 0) ? 20 : $urandom_range(1, 5);
        for (int j = 0; j < nrep; j++) begin
          logic [31:0] cnt;
          case ($urandom_range(0, 5))
            0: cnt = 0;
            1: cnt = 32'hFFFF;
            2: cnt = $urandom;
            3: cnt = $urandom_range(1, 70);
            default: cnt = $urandom_range(1, 255);
          endcase
          push_report(1'($urandom), 8'($urandom), cnt);
          if ($urandom_range(0, 5) == 0) push_stim(byte_item(8'($urandom), 0));
        end
        push_stim(byte_item(8'($urandom), 1));
        repeat ($urandom_range(1, 6))
          push_stim(query_item(2'($urandom_range(1, 3)),
                    ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 80))));
      end else if (k < 8) begin
        repeat ($urandom_range(1, 8))
          push_stim(byte_item(8'($urandom), $urandom_range(0, 7) == 0));
      end else begin
        push_stim(query_item(2'($urandom_range(1, 3)), 16'($urandom)));
      end
    end
    push_stim(byte_item(8'h00, 1));

    while (stim_q.size() > 0) begin
      int gap;
      it = stim_q.pop_front();
      gap = ($urandom_range(0, 19) == 0) ? $urandom_range(5, 30) :
            ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
      if (gap > 0) begin
        in_ch.valid <= 0;
        repeat (gap) @(negedge clk);
      end
      in_ch.valid <= 1;
      in_ch.command <= it.command; in_ch.data_byte <= it.data_byte;
      in_ch.last_byte <= it.last_byte; in_ch.query_size <= it.query_size;
      predict_result(it, r);
      if (typed_q.size() > 0) begin
        res_t t;
        logic h;
        t = typed_q.pop_front();
        h = typed_has.pop_front();
        if (h && t !== r) begin
          $error("typed row differs from prediction: %h vs %h", t, r);
          fails++;
        end
        if (h) r = t;
      end
      expected_q.push_back(r);
      do @(posedge clk); while (!in_ch.ready);
      @(negedge clk);
    end
    in_ch.valid <= 0;
    stim_done = 1;
  end

  // long hold-off once the random part is running, so the input backs up
  initial begin
    hold_off = 0;
    wait (expected_q.size() > 0);
    repeat (300) @(posedge clk);
    hold_off = 1;
    repeat (200) @(posedge clk);
    hold_off = 0;
  end

  // output side: random ready at falling edge
  initial begin
    out_ch.ready = 0;
    forever begin
      @(negedge clk);
      if (hold_off) out_ch.ready <= 0;
      else if ($urandom_range(0, 49) == 0) begin
        out_ch.ready <= 0;
        repeat ($urandom_range(5, 25)) @(negedge clk);
        out_ch.ready <= 1;
      end else out_ch.ready <= ($urandom_range(0, 3) != 0);
    end
  end

  // check results at the rising edge
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_q.size() == 0) begin
        $error("result transfer with no expectation waiting");
        fails++;
      end else begin
        res_t e;
        e = expected_q.pop_front();
        if (out_ch.reply_value !== e.reply_value) begin
          $error("reply_value: expected %0d actual %0d", e.reply_value, out_ch.reply_value);
          fails++;
        end
        if (out_ch.status !== e.status) begin
          $error("status: expected %0d actual %0d", e.status, out_ch.status);
          fails++;
        end
        if (out_ch.input_reports !== e.input_reports) begin
          $error("input_reports: expected %0d actual %0d", e.input_reports,
                 out_ch.input_reports);
          fails++;
        end
        if (out_ch.output_reports !== e.output_reports) begin
          $error("output_reports: expected %0d actual %0d", e.output_reports,
                 out_ch.output_reports);
          fails++;
        end
        if (out_ch.largest_input !== e.largest_input) begin
          $error("largest_input: expected %0d actual %0d", e.largest_input,
                 out_ch.largest_input);
          fails++;
        end
        if (out_ch.largest_output !== e.largest_output) begin
          $error("largest_output: expected %0d actual %0d", e.largest_output,
                 out_ch.largest_output);
          fails++;
        end
      end
    end
  end

  // watchdog on cycles with no transfer on either side, and the end of run
  initial begin
    fails = 0;
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles > 2000) begin
        $display("[hid_report_descriptor_parser] ERROR");
        $finish;
      end
      if (stim_done && expected_q.size() == 0) begin
        repeat (40) @(posedge clk);
        if (fails == 0 && expected_q.size() == 0) $display("[hid_report_descriptor_parser] OK");
        else $display("[hid_report_descriptor_parser] ERROR");
        $finish;
      end
    end
  end

endmodule

FILE: files.f
rtl/hidrd_pkg.sv
rtl/hidrd_if.sv
rtl/hidrd_front.sv
rtl/hidrd_queue.sv
rtl/hidrd_back.sv
rtl/hid_report_descriptor_parser.sv
dv/hidrd_test_if.sv
dv/hid_report_descriptor_parser_test.sv
